@@ sv/por_pkg.sv @@
// Shared constants, result type and arctangent table for the planar odometry integrator.
`default_nettype none
package por_pkg;

  localparam logic signed [31:0] PI_Q      = 32'sd843314857;
  localparam logic signed [31:0] TWO_PI_Q  = 32'sd1686629714;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
  localparam logic signed [31:0] CORD_GAIN = 32'sd652032874;
  localparam logic signed [31:0] ONE_Q30   = 32'sd1073741824;

  // Serial multiplier geometry: the multiplier operand is consumed one bit a cycle.
  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Exponent of the largest power-of-two multiple of two pi used by the heading wrap;
  // the reduction takes WRAP_TOP + 1 steps.
  localparam logic [3:0] WRAP_TOP = 4'd11;

  typedef struct packed {
    logic               done;
    logic signed [31:0] sin;
    logic signed [31:0] cos;
  } cord_res_t;

  // Arctangent of 2^-i in Q4.28.
  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    logic signed [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'sd210828714;
        5'd1:  r = 32'sd124459457;
        5'd2:  r = 32'sd65760959;
        5'd3:  r = 32'sd33381290;
        5'd4:  r = 32'sd16755422;
        5'd5:  r = 32'sd8385879;
        5'd6:  r = 32'sd4193963;
        5'd7:  r = 32'sd2097109;
        5'd8:  r = 32'sd1048571;
        5'd9:  r = 32'sd524287;
        5'd10: r = 32'sd262144;
        5'd11: r = 32'sd131072;
        5'd12: r = 32'sd65536;
        5'd13: r = 32'sd32768;
        5'd14: r = 32'sd16384;
        5'd15: r = 32'sd8192;
        5'd16: r = 32'sd4096;
        5'd17: r = 32'sd2048;
        5'd18: r = 32'sd1024;
        5'd19: r = 32'sd512;
        5'd20: r = 32'sd256;
        5'd21: r = 32'sd128;
        5'd22: r = 32'sd64;
        5'd23: r = 32'sd32;
        5'd24: r = 32'sd16;
        5'd25: r = 32'sd8;
        5'd26: r = 32'sd4;
        5'd27: r = 32'sd2;
        5'd28: r = 32'sd1;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/por_cordic.sv @@
// Iterative CORDIC unit giving clamped sine and cosine of a Q4.28 angle, one rotation a cycle.
`default_nettype none
module por_cordic #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output por_pkg::cord_res_t      res
);

  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  logic signed [33:0] x, y, x_next, y_next;
  logic signed [32:0] z, z_next;
  logic [5:0]         idx;
  logic               busy, neg, last;
  logic signed [33:0] sx, sy;
  logic signed [31:0] at;

  function automatic logic signed [31:0] clamp(input logic signed [33:0] v);
    logic signed [33:0] hi;
    begin
      hi = 34'(por_pkg::ONE_Q30);
      if (v > hi) return por_pkg::ONE_Q30;
      if (v < -hi) return -por_pkg::ONE_Q30;
      return 32'(v);
    end
  endfunction

  always_comb begin
    at = por_pkg::atan_q28(idx[4:0]);
    sx = x >>> idx[4:0];
    sy = y >>> idx[4:0];
    if (z >= 0) begin
      x_next = x - sy;
      y_next = y + sx;
      z_next = z - 33'(at);
    end else begin
      x_next = x + sy;
      y_next = y - sx;
      z_next = z + 33'(at);
    end
    last = (idx == 6'(NSTEP - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        x    <= 34'(por_pkg::CORD_GAIN);
        y    <= '0;
        if (angle > por_pkg::HALF_PI_Q) begin
          z   <= 33'(angle) - 33'(por_pkg::PI_Q);
          neg <= 1'b1;
        end else if (angle < -por_pkg::HALF_PI_Q) begin
          z   <= 33'(angle) + 33'(por_pkg::PI_Q);
          neg <= 1'b1;
        end else begin
          z   <= 33'(angle);
          neg <= 1'b0;
        end
      end else if (busy) begin
        x   <= x_next;
        y   <= y_next;
        z   <= z_next;
        idx <= idx + 6'd1;
        if (last) begin
          busy     <= 1'b0;
          res.done <= 1'b1;
          res.sin  <= clamp(neg ? -y_next : y_next);
          res.cos  <= clamp(neg ? -x_next : x_next);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/por_mul.sv @@
// Bit-serial signed multiplier that takes one multiplier bit per cycle.
`default_nettype none
module por_mul (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [por_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [por_pkg::MUL_B_W-1:0]  b,
  output logic signed [por_pkg::MUL_P_W-1:0]       prod,
  output logic                                     done
);

  localparam int CW = $clog2(por_pkg::MUL_B_W);
  localparam int PW = por_pkg::MUL_P_W;

  logic signed [por_pkg::MUL_P_W-1:0] mc;
  logic [por_pkg::MUL_B_W-1:0]        mp;
  logic [CW-1:0]                      cnt;
  logic                               busy, top;

  assign top = (cnt == CW'(por_pkg::MUL_B_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mc   <= PW'(a);
        mp   <= b;
        prod <= '0;
      end else if (busy) begin
        // The sign bit of the multiplier carries negative weight.
        if (mp[0]) prod <= top ? prod - mc : prod + mc;
        mc  <= mc <<< 1;
        mp  <= mp >> 1;
        cnt <= cnt + CW'(1);
        if (top) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/planar_odometry_integrator_core.sv @@
// Top level of the planar dead-reckoning odometry integrator.
// A velocity command transaction (func 0) latches the body velocities and gives no
// result. A tick transaction (func 1) runs from acceptance to the published result
// through these steps (CORDIC_STEPS counts at most 32): one iterative CORDIC pass
// for the sine and cosine of the heading, seven bit-serial 40 by 32 bit
// multiplications on a single shared multiplier, twelve steps of modulo reduction for
// the heading wrap and a second CORDIC pass for the half-angle quaternion. The shared
// serial multiplier accounts for most of the processing time, and the next transaction
// can be accepted in the cycle after the result is published. Input is taken only
// while the block is idle, but a finished result sits in the output register and a new
// transaction may be accepted while it waits to be taken. Positions saturate at the
// POS_WIDTH signed range; the low 48 bits are shown on the ports.
`default_nettype none
module planar_odometry_integrator_core #(
  parameter int CORDIC_STEPS = 24,
  parameter int POS_WIDTH    = 48
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic signed [23:0] lin_x,
  input  wire logic signed [23:0] lin_y,
  input  wire logic signed [23:0] ang_z,
  input  wire logic [19:0]        elapsed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      pos_x,
  output logic signed [47:0]      pos_y,
  output logic signed [30:0]      heading,
  output logic signed [31:0]      quat_z,
  output logic signed [31:0]      quat_w,
  output logic signed [23:0]      vel_x,
  output logic signed [23:0]      vel_y,
  output logic signed [23:0]      vel_yaw
);

  localparam int PW = por_pkg::MUL_P_W;
  localparam int SW = ((POS_WIDTH > 42) ? POS_WIDTH : 42) + 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SINCOS = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_WRAP   = 6'b001000,
    ST_QUAT   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    OP_VXC = 3'd0, OP_VYS = 3'd1, OP_VXS = 3'd2, OP_VYC = 3'd3,
    OP_RXT = 3'd4, OP_RYT = 3'd5, OP_WZT = 3'd6
  } op_t;

  state_t state;
  op_t    op;

  logic signed [POS_WIDTH-1:0] acc_x, acc_y;
  logic signed [31:0]          acc_heading;
  logic signed [23:0]          held_vx, held_vy, held_wz;
  logic [19:0]                 dt;
  logic signed [31:0]          s_r, c_r, cord_ang;
  logic signed [PW-1:0]        t_r;
  logic signed [39:0]          rx, ry;
  logic signed [42:0]          rem;
  logic [3:0]                  k;
  logic                        cord_go, mul_go;

  por_pkg::cord_res_t             cres;
  logic signed [por_pkg::MUL_A_W-1:0] mul_a;
  logic signed [por_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               prod;
  logic                               mul_done;

  por_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_go), .angle(cord_ang), .res(cres)
  );

  por_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .prod(prod), .done(mul_done)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (op)
      OP_VXC:  begin mul_a = 40'(held_vx); mul_b = c_r; end
      OP_VYS:  begin mul_a = 40'(held_vy); mul_b = s_r; end
      OP_VXS:  begin mul_a = 40'(held_vx); mul_b = s_r; end
      OP_VYC:  begin mul_a = 40'(held_vy); mul_b = c_r; end
      OP_RXT:  begin mul_a = rx;           mul_b = signed'(32'(dt)); end
      OP_RYT:  begin mul_a = ry;           mul_b = signed'(32'(dt)); end
      default: begin mul_a = 40'(held_wz); mul_b = signed'(32'(dt)); end
    endcase
  end

  // Rounded products and the saturating position update.
  logic signed [39:0]   rx_new, ry_new, dth;
  logic signed [41:0]   dpos;
  logic signed [SW-1:0] pmax, pmin, sum_x, sum_y;
  logic signed [POS_WIDTH-1:0] sat_x, sat_y;

  always_comb begin
    rx_new = 40'((t_r - prod + PW'(32768)) >>> 16);
    ry_new = 40'((t_r + prod + PW'(32768)) >>> 16);
    dpos   = 42'((prod + PW'(64'sd536870912)) >>> 30);
    dth    = 40'((prod + PW'(8)) >>> 4);
    pmax   = SW'(signed'({1'b0, {(POS_WIDTH-1){1'b1}}}));
    pmin   = -pmax - SW'(1);
    sum_x  = SW'(acc_x) + SW'(dpos);
    sum_y  = SW'(acc_y) + SW'(dpos);
    sat_x  = (sum_x > pmax) ? POS_WIDTH'(pmax) :
             (sum_x < pmin) ? POS_WIDTH'(pmin) : POS_WIDTH'(sum_x);
    sat_y  = (sum_y > pmax) ? POS_WIDTH'(pmax) :
             (sum_y < pmin) ? POS_WIDTH'(pmin) : POS_WIDTH'(sum_y);
  end

  // One step of the signed modulo reduction by two pi, largest multiple first.
  logic signed [42:0] mk, rem_step, rem_fix, head_new;

  always_comb begin
    mk       = 43'(por_pkg::TWO_PI_Q) <<< k;
    if (rem >= mk)     rem_step = rem - mk;
    else if (rem < 0)  rem_step = rem + mk;
    else               rem_step = rem;
    rem_fix  = (rem_step < 0) ? rem_step + 43'(por_pkg::TWO_PI_Q) : rem_step;
    head_new = rem_fix - 43'(por_pkg::PI_Q);
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      op          <= OP_VXC;
      cord_go     <= 1'b0;
      mul_go      <= 1'b0;
      out_valid   <= 1'b0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      held_vx     <= '0;
      held_vy     <= '0;
      held_wz     <= '0;
    end else begin
      cord_go <= 1'b0;
      mul_go  <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (func) begin
              dt       <= elapsed;
              cord_ang <= acc_heading;
              cord_go  <= 1'b1;
              state    <= ST_SINCOS;
            end else begin
              held_vx <= lin_x;
              held_vy <= lin_y;
              held_wz <= ang_z;
            end
          end
        end
        ST_SINCOS: begin
          if (cres.done) begin
            s_r    <= cres.sin;
            c_r    <= cres.cos;
            op     <= OP_VXC;
            mul_go <= 1'b1;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            mul_go <= 1'b1;
            case (op)
              OP_VXC:  begin t_r <= prod;  op <= OP_VYS; end
              OP_VYS:  begin rx <= rx_new; op <= OP_VXS; end
              OP_VXS:  begin t_r <= prod;  op <= OP_VYC; end
              OP_VYC:  begin ry <= ry_new; op <= OP_RXT; end
              OP_RXT:  begin acc_x <= sat_x; op <= OP_RYT; end
              OP_RYT:  begin acc_y <= sat_y; op <= OP_WZT; end
              default: begin
                mul_go <= 1'b0;
                rem    <= 43'(acc_heading) + 43'(dth) + 43'(por_pkg::PI_Q);
                k      <= por_pkg::WRAP_TOP;
                state  <= ST_WRAP;
              end
            endcase
          end
        end
        ST_WRAP: begin
          rem <= rem_step;
          k   <= k - 4'd1;
          if (k == 4'd0) begin
            acc_heading <= 32'(head_new);
            cord_ang    <= 32'(head_new >>> 1);
            cord_go     <= 1'b1;
            state       <= ST_QUAT;
          end
        end
        ST_QUAT: begin
          if (cres.done) begin
            s_r   <= cres.sin;
            c_r   <= cres.cos;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Wait until the output register is free, then publish the result.
          if (!out_valid) begin
            out_valid <= 1'b1;
            pos_x     <= 48'(acc_x);
            pos_y     <= 48'(acc_y);
            heading   <= acc_heading[30:0];
            quat_z    <= s_r;
            quat_w    <= c_r;
            vel_x     <= held_vx;
            vel_y     <= held_vy;
            vel_yaw   <= held_wz;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_tick_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func) |=> !in_ready)
    else $error("tick transaction did not start processing");

  a_cmd_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !func) |=> in_ready)
    else $error("velocity command left the idle state");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    (acc_heading >= -por_pkg::PI_Q) && (acc_heading < por_pkg::PI_Q))
    else $error("heading outside the wrapped range");

  a_publish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_valid) |=> (out_valid && in_ready))
    else $error("finished result was not published");

endmodule
`default_nettype wire
